>>> hw/rtl/lstg_pkg.sv
// Shared types and constants of the log sweep tone generator.
`default_nettype none

package lstg_pkg;

    // Field widths fixed by the register map and sample format
    localparam int STEP_W      = 32;
    localparam int GROWTH_W    = 32;
    localparam int COUNT_CFG_W = 24;
    localparam int AMP_W       = 15;
    localparam int ROM_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    // Q2.30 step multiplier: drop this many fraction bits after the product
    localparam int GROWTH_FRAC = 30;

    // Sine table generation constants, Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_STEP   = 2'd0,
        REG_GROWTH_MULT  = 2'd1,
        REG_SAMPLE_COUNT = 2'd2,
        REG_AMPLITUDE    = 2'd3
    } t_reg_idx;

    // Sweep settings seen by the front
    typedef struct packed {
        logic [STEP_W-1:0]      start_step;
        logic [GROWTH_W-1:0]    growth_mult;
        logic [COUNT_CFG_W-1:0] sample_count;
    } t_front_cfg;

    // One classified tick handed from front to back
    typedef struct packed {
        logic               active;
        logic               last;
        logic [PHASE_W-1:0] phase;
    } t_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/lstg_in_if.sv
// Tick channel: valid/ready handshake carrying the restart flag.
`default_nettype none

interface lstg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lstg_out_if.sv
// Sample channel: valid/ready handshake carrying one PCM result.
`default_nettype none

interface lstg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_sample;
    logic               done_res;

    modport source (output valid, output sample, output last_sample, output done_res,
                    input ready);
    modport sink   (input valid, input sample, input last_sample, input done_res,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lstg_front.sv
// Sweep front: accepts ticks, advances phase, step and count, classifies each tick.
`default_nettype none

module lstg_front
    import lstg_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lstg_in_if.sink     i_tick,
    input  t_front_cfg  i_cfg,
    output logic        o_push_valid,
    output t_cmd        o_push_cmd,
    input  wire logic   i_push_ready
);

    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [COUNT_BITS-1:0] r_idx, n_idx;
    logic                  r_run, n_run;

    logic                  accept;
    logic [COUNT_BITS-1:0] count;
    logic [PHASE_W-1:0]    cur_phase;
    logic [STEP_W-1:0]     cur_step;
    logic [COUNT_BITS-1:0] cur_idx;
    logic                  cur_run;
    logic [COUNT_BITS:0]   idx_inc;
    logic                  last;
    logic [STEP_W+GROWTH_W-1:0]       prod;
    logic [STEP_W+GROWTH_W-GROWTH_FRAC-1:0] scaled;
    logic [STEP_W-1:0]     step_upd;

    assign i_tick.ready = i_push_ready;
    assign accept       = i_tick.valid && i_push_ready;
    assign count        = COUNT_BITS'(i_cfg.sample_count);

    always_comb begin
        // restart: clear phase and count, load the start step
        cur_phase = i_tick.restart ? '0 : r_phase;
        cur_step  = i_tick.restart ? i_cfg.start_step : r_step;
        cur_idx   = i_tick.restart ? '0 : r_idx;
        cur_run   = i_tick.restart ? (count != '0) : r_run;

        idx_inc = {1'b0, cur_idx} + (COUNT_BITS+1)'(1);
        last    = idx_inc >= {1'b0, count};

        prod     = cur_step * i_cfg.growth_mult;
        scaled   = prod[STEP_W+GROWTH_W-1:GROWTH_FRAC];
        // saturate a step that no longer fits
        step_upd = (scaled[STEP_W+GROWTH_W-GROWTH_FRAC-1:STEP_W] != '0) ? '1
                                                                         : scaled[STEP_W-1:0];

        n_phase = r_phase;
        n_step  = r_step;
        n_idx   = r_idx;
        n_run   = r_run;
        if (accept) begin
            if (cur_run) begin
                n_phase = cur_phase + cur_step;
                n_step  = step_upd;
                n_idx   = idx_inc[COUNT_BITS-1:0];
                n_run   = !last;
            end else begin
                n_phase = cur_phase;
                n_step  = cur_step;
                n_idx   = cur_idx;
                n_run   = 1'b0;
            end
        end

        o_push_valid      = i_tick.valid;
        o_push_cmd.active = cur_run;
        o_push_cmd.last   = cur_run && last;
        o_push_cmd.phase  = cur_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= '0;
            r_idx   <= '0;
            r_run   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_run   <= n_run;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lstg_queue.sv
// Two-entry command queue between sweep front and synthesis back.
`default_nettype none

module lstg_queue
    import lstg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    input  t_cmd      i_push_cmd,
    output logic      o_push_ready,
    output logic      o_pop_valid,
    output t_cmd      o_pop_cmd,
    input  wire logic i_pop_ready
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push, pop;

    assign o_push_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lstg_back.sv
// Synthesis back: quarter-wave ROM lookup, amplitude scaling, sign, output register.
`default_nettype none

module lstg_back
    import lstg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_pop_valid,
    input  t_cmd                  i_pop_cmd,
    output logic                  o_pop_ready,
    input  wire logic [AMP_W-1:0] i_amplitude,
    lstg_out_if.source            o_res
);

    localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;

    typedef logic [ROM_W-1:0] t_rom [ROM_DEPTH];

    // Truncating unsigned quotient by shift and subtract, used while building the table
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave table, Q0.15, built by an alternating Taylor series
    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        n;
        logic signed [63:0] sum;
        logic [63:0]        usum;
        logic [63:0]        rounded;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (SINE_ADDR_BITS + 1);
            term = x;
            sum  = '0;
            n    = 64'd1;
            for (int i = 0; i < 9; i++) begin
                if (i % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
                term = (((term * x) >> 30) * x) >> 30;
                term = div_u64(term, (n + 64'd1) * (n + 64'd2));
                n    = n + 64'd2;
            end
            if (sum < 0) begin
                sum = '0;
            end
            if (sum > $signed(ONE_Q30)) begin
                sum = $signed(ONE_Q30);
            end
            usum    = $unsigned(sum);
            rounded = ((usum * 64'd32767) + (ONE_Q30 >> 1)) >> 30;
            rom[k]  = rounded[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [SINE_ADDR_BITS-1:0] addr;
    logic                      adv1, adv2, adv3;
    logic                      pop;

    logic                 r_v1, r_v2, r_v3;
    logic [ROM_W-1:0]     r_rom;
    logic                 r_neg1, r_act1, r_last1;
    logic [AMP_W-1:0]     r_mag;
    logic                 r_neg2, r_act2, r_last2;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                 r_last3, r_done3;
    logic [ROM_W+AMP_W-1:0] prod;

    // mirror the address in quadrants one and three
    always_comb begin
        addr = i_pop_cmd.phase[PHASE_W-3 -: SINE_ADDR_BITS];
        if (i_pop_cmd.phase[PHASE_W-2]) begin
            addr = ~addr;
        end
    end

    assign adv3        = !r_v3 || o_res.ready;
    assign adv2        = !r_v2 || adv3;
    assign adv1        = !r_v1 || adv2;
    assign o_pop_ready = adv1;
    assign pop         = i_pop_valid && adv1;
    assign prod        = r_rom * i_amplitude;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rom   <= SINE_ROM[addr];
            r_neg1  <= i_pop_cmd.phase[PHASE_W-1];
            r_act1  <= i_pop_cmd.active;
            r_last1 <= i_pop_cmd.last;
        end
        if (adv2 && r_v1) begin
            r_mag   <= r_act1 ? prod[ROM_W+AMP_W-1:AMP_W] : '0;
            r_neg2  <= r_neg1;
            r_act2  <= r_act1;
            r_last2 <= r_last1;
        end
        if (adv3 && r_v2) begin
            r_sample <= r_neg2 ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            r_last3  <= r_last2;
            r_done3  <= !r_act2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_pop_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_res.valid       = r_v3;
    assign o_res.sample      = r_sample;
    assign o_res.last_sample = r_last3;
    assign o_res.done_res    = r_done3;

endmodule

`default_nettype wire

>>> hw/rtl/log_sweep_tone_generator.sv
// Logarithmic sine sweep generator: top level with register file.
//
// Usage: every transfer on i_tick is one sample tick and yields exactly one
// transfer on o_res. Set restart on a tick to begin a sweep: phase and count
// clear and the phase step loads from start_step; that tick already gives
// the first sample. Each sample the step is scaled by growth_mult (Q2.30),
// so the tone rises exponentially. After sample_count samples the final one
// carries last_sample; later ticks give zero with done_res set.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write them only while no tick is in flight, the block does not enforce it.
// Each result passes the queue, ROM read, scale and sign/output registers.
// Throughput: one tick per cycle while the receiver takes o_res; the step
// multiply and phase add are combinational in the front loop, and the ROM
// port is read once per sample.
// Reset: sweep idle, registers back to their defaults, queue and pipeline
// empty. A stalled receiver holds o_res; the back pipeline and the two-entry
// queue fill, then i_tick.ready drops until space frees up.
`default_nettype none

module log_sweep_tone_generator
    import lstg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int COUNT_BITS     = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lstg_in_if.sink                    i_tick,
    lstg_out_if.source                 o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [STEP_W-1:0]      r_start_step;
    logic [GROWTH_W-1:0]    r_growth_mult;
    logic [COUNT_CFG_W-1:0] r_sample_count;
    logic [AMP_W-1:0]       r_amplitude;

    t_front_cfg front_cfg;
    logic       push_valid, push_ready;
    t_cmd       push_cmd;
    logic       pop_valid, pop_ready;
    t_cmd       pop_cmd;

    // Register file: take the write, truncate to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_step   <= STEP_W'(1789570);
            r_growth_mult  <= GROWTH_W'(1073741824);
            r_sample_count <= COUNT_CFG_W'(48000);
            r_amplitude    <= AMP_W'(9830);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_START_STEP:   r_start_step   <= i_cfg_data[STEP_W-1:0];
                REG_GROWTH_MULT:  r_growth_mult  <= i_cfg_data[GROWTH_W-1:0];
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[COUNT_CFG_W-1:0];
                REG_AMPLITUDE:    r_amplitude    <= i_cfg_data[AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign front_cfg.start_step   = r_start_step;
    assign front_cfg.growth_mult  = r_growth_mult;
    assign front_cfg.sample_count = r_sample_count;

    // Front: advance the sweep state and classify each tick
    lstg_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (i_tick),
        .i_cfg        (front_cfg),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    // Queue: decouple the front from back-pressure on the sample side
    lstg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    // Back: turn phase into a scaled, signed sample
    lstg_back #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop_ready (pop_ready),
        .i_amplitude (r_amplitude),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
